// ===== sv/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg: shared types and constants for the integer to ASCII converter
// Format codes, character constants and the digit to character mapping.
// ----------------------------------------------------------------------------
package i2a_pkg;

  // Output format selector
  typedef enum logic [1:0] {
    FMT_SDEC = 2'd0,
    FMT_UDEC = 2'd1,
    FMT_LHEX = 2'd2,
    FMT_UHEX = 2'd3
  } fmt_e;

  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  // Map one digit (0..15) to its ASCII character
  function automatic logic [7:0] digit_to_ascii(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    if (d < 4'd10) begin
      base = CH_ZERO;
      return base + {4'd0, d};
    end else begin
      base = upper ? CH_UPPER_A : CH_LOWER_A;
      return base + {4'd0, d} - 8'd10;
    end
  endfunction

endpackage

// ===== sv/integer_to_ascii_digits.sv =====
// A word passes the sign stage, NSTG = ceil(VALUE_BITS / 4) conversion stages,
// the count stage, the serializer and the output register; its characters follow
// one per cycle with no gaps. New words enter while the single-character output
// serializer emits an earlier one; busy rises only while the count stage waits.
// Reset clears all valid bits and the serializer; no clearing pass is needed.
// The receiver cannot stall: each character is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// integer_to_ascii_digits: binary word to ASCII decimal or hex characters
// Sign stage, pipelined shift-add-3 BCD conversion (four bits per stage),
// digit count stage and a serializer that emits one character per cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_digits
  import i2a_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [1:0]            func_i,
  output logic                  valid_o,
  output logic [7:0]            ascii_code_o,
  output logic                  last_o,
  output logic [3:0]            char_count_o
);

  // Geometry derived from the word width
  localparam int NSTG  = (VALUE_BITS + 3) / 4;             // conversion stages
  localparam int PADW  = NSTG * 4;                         // padded word width
  localparam int NDIG  = ((VALUE_BITS * 1233) >> 12) + 1;  // max decimal digits
  localparam int BCDW  = NDIG * 4;
  localparam int IDXW  = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int CNTW0 = $clog2(NDIG + 2);
  localparam int CNTW  = (CNTW0 > 4) ? CNTW0 : 4;

  // One shift-add-3 pass over four bits
  function automatic logic [BCDW+PADW-1:0] dabble4(input logic [BCDW+PADW-1:0] x_in);
    logic [BCDW+PADW-1:0] x;
    x = x_in;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (x[PADW+4*d +: 4] >= 4'd5) begin
          x[PADW+4*d +: 4] = x[PADW+4*d +: 4] + 4'd3;
        end
      end
      x = x << 1;
    end
    return x;
  endfunction

  // Pipeline registers, index 0 is the sign stage
  logic [NSTG:0]            vld_q;
  logic [NSTG:0][PADW-1:0]  bin_q;
  logic [NSTG:0][BCDW-1:0]  bcd_q;
  logic [NSTG:0][PADW-1:0]  mag_q;
  logic [NSTG:0]            neg_q;
  logic [NSTG:0]            hex_q;
  logic [NSTG:0]            upper_q;

  // Count stage
  logic                     cs_vld_q;
  logic [NDIG-1:0][3:0]     cs_dig_q;
  logic                     cs_neg_q;
  logic                     cs_upper_q;
  logic [CNTW-1:0]          cs_total_q;

  // Serializer
  logic                     ser_active_q;
  logic [NDIG-1:0][3:0]     ser_dig_q;
  logic                     ser_neg_q;
  logic                     ser_upper_q;
  logic [CNTW-1:0]          ser_total_q;
  logic [CNTW-1:0]          ser_idx_q;

  // Output word registers
  logic                     valid_q;
  logic [7:0]               ascii_q;
  logic                     last_q;
  logic [3:0]               count_q;

  logic                     accept;
  logic                     ser_done;
  logic                     ser_free;
  logic                     stall;
  fmt_e                     fmt_in;
  logic                     neg_in;
  logic [VALUE_BITS-1:0]    mag_in;

  // Hold all stages before the serializer while the count stage waits on it
  assign ser_done = ser_active_q && (ser_idx_q == ser_total_q - CNTW'(1));
  assign ser_free = !ser_active_q || ser_done;
  assign stall    = cs_vld_q && !ser_free;
  assign busy     = stall;
  assign accept   = start && !busy;

  // Take the magnitude of a signed negative word
  assign fmt_in = fmt_e'(func_i);
  assign neg_in = (fmt_in == FMT_SDEC) && value_i[VALUE_BITS-1];
  assign mag_in = neg_in ? (~value_i + VALUE_BITS'(1)) : value_i;

  // Widen the hex nibbles to the digit field
  logic [BCDW-1:0] hex_ext;
  assign hex_ext = BCDW'(mag_q[NSTG]);

  // Count digits and pick decimal or hex digits
  logic [NDIG-1:0][3:0] dig_sel;
  logic [CNTW-1:0]      nd;
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (hex_q[NSTG]) begin
        dig_sel[d] = hex_ext[4*d +: 4];
      end else begin
        dig_sel[d] = bcd_q[NSTG][4*d +: 4];
      end
    end
    nd = CNTW'(1);
    for (int d = 1; d < NDIG; d++) begin
      if (dig_sel[d] != 4'd0) begin
        nd = CNTW'(d + 1);
      end
    end
  end

  // Advance the conversion and count stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      cs_vld_q <= 1'b0;
    end else if (!stall) begin
      vld_q[0] <= accept;
      for (int s = 0; s < NSTG; s++) begin
        vld_q[s+1] <= vld_q[s];
      end
      cs_vld_q <= vld_q[NSTG];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      bin_q[0]   <= PADW'(mag_in);
      mag_q[0]   <= PADW'(mag_in);
      bcd_q[0]   <= '0;
      neg_q[0]   <= neg_in;
      hex_q[0]   <= (fmt_in == FMT_LHEX) || (fmt_in == FMT_UHEX);
      upper_q[0] <= (fmt_in == FMT_UHEX);
      for (int s = 0; s < NSTG; s++) begin
        {bcd_q[s+1], bin_q[s+1]} <= dabble4({bcd_q[s], bin_q[s]});
        mag_q[s+1]   <= mag_q[s];
        neg_q[s+1]   <= neg_q[s];
        hex_q[s+1]   <= hex_q[s];
        upper_q[s+1] <= upper_q[s];
      end
      cs_dig_q   <= dig_sel;
      cs_neg_q   <= neg_q[NSTG];
      cs_upper_q <= upper_q[NSTG];
      cs_total_q <= nd + CNTW'(neg_q[NSTG]);
    end
  end

  // Load a new word into the serializer or step to the next character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_active_q <= 1'b0;
      ser_idx_q    <= '0;
    end else if (ser_free) begin
      ser_active_q <= cs_vld_q;
      ser_idx_q    <= '0;
    end else begin
      ser_idx_q    <= ser_idx_q + CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_free) begin
      ser_dig_q   <= cs_dig_q;
      ser_neg_q   <= cs_neg_q;
      ser_upper_q <= cs_upper_q;
      ser_total_q <= cs_total_q;
    end
  end

  // Pick the current character, most significant first
  logic [CNTW-1:0] pos;
  logic [7:0]      ch;
  always_comb begin
    pos = ser_total_q - CNTW'(1) - ser_idx_q;
    if (ser_neg_q && (ser_idx_q == '0)) begin
      ch = CH_MINUS;
    end else begin
      ch = digit_to_ascii(ser_dig_q[pos[IDXW-1:0]], ser_upper_q);
    end
  end

  // Register the output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= ser_active_q;
      last_q  <= ser_done;
    end
  end

  always_ff @(posedge clk_i) begin
    ascii_q <= ch;
    count_q <= ser_done ? ser_total_q[3:0] : 4'd0;
  end

  assign valid_o      = valid_q;
  assign ascii_code_o = ascii_q;
  assign last_o       = last_q;
  assign char_count_o = count_q;

  // A run never ends without its last mark, and last only comes with valid
  a_last_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> valid_o)
    else $error("last without valid");

  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> valid_o)
    else $error("gap inside a character run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (cs_vld_q && $stable(cs_total_q)))
    else $error("count stage changed while stalled");

endmodule
